### src/isq_pkg.sv
package isq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int POS_W        = 8;
  localparam int VAL_W        = 32;
  localparam int STAT_W       = 2;
  localparam int ECNT_W       = 7;

  typedef enum logic [2:0] {
    CMD_READ,
    CMD_HEAD,
    CMD_TAIL,
    CMD_AT,
    CMD_DEL
  } isq_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE,
    ST_RANGE,
    ST_FULL
  } isq_status_t;

  // broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } isq_ctl_t;

endpackage

### src/isq_cell.sv
module isq_cell
  import isq_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  isq_ctl_t         ctl,
  input  logic [VAL_W-1:0] left,
  input  logic [VAL_W-1:0] right,
  output logic [VAL_W-1:0] data,
  output logic [VAL_W-1:0] rd
);

  localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

  logic [VAL_W-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctl.ins) begin
      if (IDX_P == ctl.pos) begin
        data_next = ctl.value;
      end else if (IDX_P > ctl.pos) begin
        data_next = left;
      end
    end else if (ctl.del && (IDX_P >= ctl.pos)) begin
      data_next = right;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign rd = (IDX_P == ctl.pos) ? data : '0;

endmodule

### src/indexed_sequence_store_core.sv
// Ordered store of up to CAPACITY signed 32-bit values, one value per cell.
// s_* carries command words, m_* carries one result word per command.
// A command reads a position, inserts at head, tail or a position, or
// deletes at a position; on insert or delete every cell loads from its
// neighbour or the new value, or holds, all in the same cycle.
// The result is registered and shows on m_tvalid in the cycle after
// the command word is taken.
// Throughput: one command per cycle while results are taken; the cell row
// shifts as the command is taken and the result stage is registered.
// s_tready is low only while a result waits and m_tready is low, so a
// stalled receiver holds both the result and the store.
// Reset clears the entry count and the result valid flag; cell contents
// are not cleared and are only read below the count.
// Out-of-range commands and inserts while full leave the store unchanged.
module indexed_sequence_store_core
  import isq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // command[2:0], position[10:3], value[42:11]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // read_value[31:0], status[33:32], entry_count[40:34]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [2:0]       command;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;
  assign command  = s_tdata[2:0];
  assign position = s_tdata[10:3];
  assign value    = s_tdata[42:11];

  logic [CNT_W-1:0]  count, count_next;
  logic [VAL_W-1:0]  rd_value, rd_value_next;
  logic [STAT_W-1:0] status, status_next;
  logic [ECNT_W-1:0] entry_count;
  logic              accept;
  logic [CMP_W-1:0]  cnt_x, pos_x, ipos;
  logic              is_ins;
  isq_ctl_t          ctl;
  logic [VAL_W-1:0]  cell_data [CAPACITY];
  logic [VAL_W-1:0]  cell_rd [CAPACITY];
  logic [VAL_W-1:0]  rd_sel;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cnt_x    = CMP_W'(count);
  assign pos_x    = CMP_W'(position);

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  always_comb begin
    count_next    = count;
    rd_value_next = '0;
    status_next   = ST_RANGE;
    is_ins        = 1'b0;
    ipos          = pos_x;
    ctl.ins       = 1'b0;
    ctl.del       = 1'b0;
    ctl.value     = value;
    case (command)
      CMD_READ: begin
        if (pos_x < cnt_x) begin
          rd_value_next = rd_sel;
          status_next   = ST_DONE;
        end else begin
          rd_value_next = '1;
        end
      end
      CMD_HEAD: begin
        is_ins = 1'b1;
        ipos   = '0;
      end
      CMD_TAIL: begin
        is_ins = 1'b1;
        ipos   = cnt_x;
      end
      CMD_AT: begin
        is_ins = 1'b1;
      end
      CMD_DEL: begin
        if (pos_x < cnt_x) begin
          status_next = ST_DONE;
          ctl.del     = accept;
          count_next  = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
    if (is_ins) begin
      if (ipos > cnt_x) begin
        status_next = ST_RANGE;
      end else if (count == CNT_W'(CAPACITY)) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_DONE;
        ctl.ins     = accept;
        count_next  = count + CNT_W'(1);
      end
    end
    ctl.pos = POS_W'(ipos);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    isq_cell #(
      .IDX (g)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .left  (left),
      .right (right),
      .data  (cell_data[g]),
      .rd    (cell_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_value    <= rd_value_next;
      status      <= status_next;
      entry_count <= ECNT_W'(count_next);
    end
  end

  assign m_tdata = {7'b0, entry_count, status, rd_value};

endmodule

### tb/tb_indexed_sequence_store_core.sv
module tb_indexed_sequence_store_core;
  import isq_pkg::*;

  localparam int          CAPACITY   = CAPACITY_DEF;
  localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
  localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
  localparam logic [31:0] VAL_MAX    = 32'h7fff_ffff;
  localparam logic [31:0] VAL_MIN    = 32'h8000_0000;
  localparam int          HOLD_AT    = 60;
  localparam int          HOLD_LEN   = 120;
  localparam int          QUIET_LO   = 420;
  localparam int          QUIET_HI   = 520;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  at;
    logic [31:0] val;
    int unsigned gap;
    bit          drain;
  } store_cmd_t;

  typedef struct packed {
    logic [31:0] rd;
    isq_status_t st;
    logic [6:0]  cnt;
  } store_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // command[2:0], position[10:3], value[42:11]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;       // read_value[31:0], status[33:32], entry_count[40:34]

  store_cmd_t    cmd_backlog[$];
  store_result_t awaited_results[$];
  int            errors = 0;

  // shadow of the store
  logic [31:0] cells[CAPACITY];
  int unsigned fill = 0;

  indexed_sequence_store_core #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic isq_status_t shift_in(int unsigned at, logic [31:0] v);
    if (at > fill) return ST_RANGE;
    if (fill >= CAPACITY) return ST_FULL;
    for (int i = fill; i > at; i--) cells[i] = cells[i-1];
    cells[at] = v;
    fill++;
    return ST_DONE;
  endfunction

  function automatic store_result_t apply_command(logic [47:0] word);
    logic [2:0]    op;
    logic [7:0]    at;
    logic [31:0]   v;
    store_result_t r;
    op   = word[2:0];
    at   = word[10:3];
    v    = word[42:11];
    r.rd = '0;
    case (op)
      CMD_READ: begin
        if (at < fill) begin
          r.rd = cells[at];
          r.st = ST_DONE;
        end else begin
          r.rd = '1;
          r.st = ST_RANGE;
        end
      end
      CMD_HEAD: r.st = shift_in(0, v);
      CMD_TAIL: r.st = shift_in(fill, v);
      CMD_AT:   r.st = shift_in(at, v);
      CMD_DEL: begin
        if (at >= fill) begin
          r.st = ST_RANGE;
        end else begin
          for (int i = at; i + 1 < fill; i++) cells[i] = cells[i+1];
          fill--;
          r.st = ST_DONE;
        end
      end
      default: r.st = ST_RANGE;
    endcase
    r.cnt = 7'(fill);
    return r;
  endfunction

  function automatic store_cmd_t random_cmd(int unsigned ins_pct, int unsigned del_pct,
                                            int unsigned span, bit busy);
    store_cmd_t  c;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) c.op = 3'($urandom_range(CMD_HEAD, CMD_AT));
    else if (r < ins_pct + del_pct) c.op = CMD_DEL;
    else if (r < 98) c.op = CMD_READ;
    else c.op = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    c.at = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, span));
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       c.val = VAL_MAX;
        1:       c.val = VAL_MIN;
        2:       c.val = '0;
        default: c.val = '1;
      endcase
    end else begin
      c.val = $urandom;
    end
    r = $urandom_range(0, 99);
    if (!busy || r < 65) c.gap = 0;
    else if (r < 95) c.gap = $urandom_range(1, 3);
    else c.gap = $urandom_range(8, 30);
    c.drain = 1'b0;
    return c;
  endfunction

  task automatic add(logic [2:0] op, logic [7:0] at, logic [31:0] val);
    store_cmd_t c;
    c.op    = op;
    c.at    = at;
    c.val   = val;
    c.gap   = 0;
    c.drain = 1'b0;
    cmd_backlog.push_back(c);
  endtask

  // first word of each segment waits until the store has answered everything
  task automatic add_segment(int n, int unsigned ins_pct, int unsigned del_pct,
                             int unsigned span, bit busy);
    store_cmd_t c;
    for (int k = 0; k < n; k++) begin
      c       = random_cmd(ins_pct, del_pct, span, busy);
      c.drain = (k == 0);
      cmd_backlog.push_back(c);
    end
  endtask

  // command driver
  int unsigned gap_left = 0;
  store_cmd_t  head;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_backlog.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (cmd_backlog[0].drain &&
                   (s_tvalid || m_tvalid || awaited_results.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else if (cmd_backlog[0].gap != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= cmd_backlog[0].gap - 1;
        cmd_backlog[0].gap = 0;
      end else begin
        head = cmd_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, head.val, head.at, head.op};
      end
    end
  end

  // result receiver
  int unsigned stall_left = 0;
  int unsigned taken = 0;
  int unsigned roll;
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) taken <= taken + 1;
      roll = $urandom_range(0, 99);
      if (stall_left != 0) begin
        m_tready   <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (m_tvalid && m_tready && taken == HOLD_AT) begin
        m_tready   <= 1'b0;
        stall_left <= HOLD_LEN;
      end else if (taken >= QUIET_LO && taken < QUIET_HI) begin
        m_tready <= 1'b1;
      end else if (roll < 12) begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else if (roll < 14) begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(8, 30);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // prediction and check
  store_result_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) awaited_results.push_back(apply_command(s_tdata));
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result word %h with none awaited", m_tdata);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (m_tdata[31:0] !== want.rd) begin
            $error("read_value: expected %h, got %h", want.rd, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[33:32] !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, m_tdata[33:32]);
            errors++;
          end
          if (m_tdata[40:34] !== want.cnt) begin
            $error("entry_count: expected %0d, got %0d", want.cnt, m_tdata[40:34]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    add(CMD_READ, 8'd0, '0);
    add(CMD_DEL, 8'd0, '0);
    add(CMD_AT, 8'd1, VAL_MAX);
    add(CMD_AT, 8'd0, VAL_MAX);
    add(CMD_HEAD, 8'd255, VAL_MIN);
    add(CMD_TAIL, 8'd0, '1);
    add(CMD_AT, 8'd3, '0);
    add(CMD_AT, 8'd2, 32'h1234_5678);
    for (int p = 0; p <= 5; p++) add(CMD_READ, 8'(p), '1);
    add(CMD_READ, 8'd255, '0);
    add(CMD_DEL, 8'd255, '0);
    add(CMD_DEL, 8'd2, '0);
    add(CMD_DEL, 8'd3, '0);
    for (int s = CMD_SPARE_LO; s <= CMD_SPARE_HI; s++) add(3'(s), 8'd255, '1);
    add(CMD_DEL, 8'd0, '0);
    add(CMD_READ, 8'd0, '0);

    add_segment(150, 40, 25, 12, 1'b1);
    add_segment(200, 75, 10, 70, 1'b1);  // fills up, then refused inserts
    add_segment(120, 45, 30, 66, 1'b0);
    add_segment(180, 15, 70, 16, 1'b1);  // drains down

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (cmd_backlog.size() != 0 || s_tvalid || m_tvalid || awaited_results.size() != 0);
    repeat (8) @(negedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3200000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
src/isq_pkg.sv
src/isq_cell.sv
src/indexed_sequence_store_core.sv
tb/tb_indexed_sequence_store_core.sv
